/* sv/sid_pkg.sv */
// Shared types and constants for the signed integer divider.
`timescale 1ns / 1ps
package sid_pkg;

   // Default operand width.
   localparam int DATA_WIDTH_DEF = 32;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_FIX
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture operands and take magnitudes
      logic step;    // run one restoring division step
      logic finish;  // apply signs and write the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;  // output register can take a result this cycle
   } stat_type;

endpackage

/* sv/sid_ctrl.sv */
// Controller state machine of the signed integer divider.
`timescale 1ns / 1ps
module sid_ctrl #(
   parameter int DATA_WIDTH = sid_pkg::DATA_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  sid_pkg::stat_type stat,
   output sid_pkg::cmd_type  cmd
);
   import sid_pkg::*;

   localparam int CNT_W = $clog2(DATA_WIDTH);

   state_type        state_ff;
   state_type        state_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   // Next state and step count
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DIV;
               count_in = CNT_W'(DATA_WIDTH - 1);
            end
         end
         ST_DIV: begin
            count_in = count_ff - 1'b1;
            if (count_ff == '0) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs per state
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
         end
         ST_FIX: begin
            cmd.finish = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

/* sv/sid_dpath.sv */
// Datapath of the signed integer divider: restoring shift-subtract and sign fixup.
`timescale 1ns / 1ps
module sid_dpath #(
   parameter int DATA_WIDTH = sid_pkg::DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sid_pkg::cmd_type      cmd,
   output sid_pkg::stat_type     stat,
   input  logic [DATA_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [DATA_WIDTH-1:0] quotient,
   output logic [DATA_WIDTH-1:0] remainder,
   output logic                  divide_by_zero
);
   import sid_pkg::*;

   localparam int DW = DATA_WIDTH;

   // Working registers
   logic [DW-1:0] a_ff, a_in;
   logic [DW-1:0] div_ff, div_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic          sa_ff, sa_in;
   logic          sq_ff, sq_in;
   logic          zero_ff, zero_in;

   // Output register
   logic [DW-1:0] q_out_ff, q_out_in;
   logic [DW-1:0] r_out_ff, r_out_in;
   logic          z_out_ff, z_out_in;
   logic          vld_ff, vld_in;

   logic          sa;
   logic          sb;
   logic [DW:0]   shifted;
   logic [DW+1:0] diff;

   assign sa       = dividend[DW-1];
   assign sb       = divisor[DW-1];
   assign shifted  = {rem_ff, quo_ff[DW-1]};
   assign diff     = {1'b0, shifted} - {2'b00, div_ff};
   assign stat.out_free = !vld_ff || rsp_tready;

   // Load magnitudes, then shift one quotient bit per step
   always_comb begin
      a_in    = a_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      sa_in   = sa_ff;
      sq_in   = sq_ff;
      zero_in = zero_ff;
      if (cmd.load) begin
         a_in    = dividend;
         div_in  = sb ? (~divisor + 1'b1) : divisor;
         quo_in  = sa ? (~dividend + 1'b1) : dividend;
         rem_in  = '0;
         sa_in   = sa;
         sq_in   = sa ^ sb;
         zero_in = (divisor == '0);
      end else if (cmd.step) begin
         if (!diff[DW+1]) begin
            rem_in = diff[DW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
      end
   end

   // Apply signs into the output register; drop the result once taken
   always_comb begin
      q_out_in = q_out_ff;
      r_out_in = r_out_ff;
      z_out_in = z_out_ff;
      vld_in   = vld_ff && !rsp_tready;
      if (cmd.finish) begin
         vld_in   = 1'b1;
         z_out_in = zero_ff;
         if (zero_ff) begin
            q_out_in = '0;
            r_out_in = a_ff;
         end else begin
            q_out_in = sq_ff ? (~quo_ff + 1'b1) : quo_ff;
            r_out_in = sa_ff ? (~rem_ff + 1'b1) : rem_ff;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      div_ff   <= div_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      sa_ff    <= sa_in;
      sq_ff    <= sq_in;
      zero_ff  <= zero_in;
      q_out_ff <= q_out_in;
      r_out_ff <= r_out_in;
      z_out_ff <= z_out_in;
   end

   // Output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign rsp_tvalid     = vld_ff;
   assign quotient       = q_out_ff;
   assign remainder      = r_out_ff;
   assign divide_by_zero = z_out_ff;

endmodule

/* sv/signed_int_divider.sv */
// Top level of the signed integer divider.
//
// Truncating signed division of two DATA_WIDTH-bit two's complement values.
// Input channel req_: tdata carries dividend (low bits) and divisor.
// Result channel rsp_: tdata carries quotient (low bits) and remainder,
// tuser carries the divide-by-zero flag. Remainder takes the dividend's sign.
// A zero divisor gives quotient 0, remainder equal to the dividend, flag set.
// The most negative dividend over minus one wraps the quotient to itself.
// Steps: accept and take magnitudes, then the restoring shift-subtract loop
// (one quotient bit per cycle, until all DATA_WIDTH bits are formed), then
// apply signs into the output register. One item is worked on at a time;
// req_tready is high only while the divider is idle.
// The output register holds a finished item while the next one divides; if
// rsp_tready stays low, the next item waits in the sign stage until the
// output register frees, and req_tready stays low meanwhile.
// Reset (synchronous, active high) returns to idle and drops any item.
`timescale 1ns / 1ps
module signed_int_divider #(
   parameter int DATA_WIDTH = sid_pkg::DATA_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // dividend, divisor, zero fill to whole bytes
   input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]    req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // quotient, remainder, zero fill to whole bytes
   output logic [((2*DATA_WIDTH+7)/8)*8-1:0]    rsp_tdata,
   // divide_by_zero
   output logic                                 rsp_tuser
);
   import sid_pkg::*;

   localparam int DW    = DATA_WIDTH;
   localparam int BUS_W = ((2*DATA_WIDTH+7)/8)*8;

   cmd_type       cmd;
   stat_type      stat;
   logic [DW-1:0] quotient;
   logic [DW-1:0] remainder;

   sid_ctrl #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sid_dpath #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .dividend       (req_tdata[DW-1:0]),
      .divisor        (req_tdata[2*DW-1:DW]),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .quotient       (quotient),
      .remainder      (remainder),
      .divide_by_zero (rsp_tuser)
   );

   // Pack the result item
   assign rsp_tdata = BUS_W'({remainder, quotient});

`ifndef SYNTHESIS
   // An accepted item keeps the divider busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("divider accepted two items back to back");

   // A divide-by-zero result carries a zero quotient
   a_zero_quotient: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[DW-1:0] == '0)
      else $error("nonzero quotient on divide by zero");

   // A new result appears only after the divider was busy
   a_result_follows_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without a division in flight");
`endif

endmodule

/* tb/sv/signed_int_divider_tb.sv */
// Self-checking testbench for the signed integer divider, random and directed items.
`timescale 1ns / 1ps
module signed_int_divider_tb;

   localparam int DW         = sid_pkg::DATA_WIDTH_DEF;
   localparam int TDATA_W    = ((2*DW+7)/8)*8;
   localparam int QUIET_MAX  = 1000;     // cycles with no item moving on either side
   localparam int TAIL_WAIT  = DW + 8;   // settle time after the last result
   localparam int RAND_ITEMS = 850;

   localparam logic [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
   localparam logic [DW-1:0] MOST_POS = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] MINUS_1  = '1;

   // one operand pair plus the handshake pacing that applies while it is offered
   typedef struct {
      logic [DW-1:0] dividend;
      logic [DW-1:0] divisor;
      int unsigned   send_idle_pct;
      int unsigned   recv_stall_pct;
      bit            wait_drain;
   } div_item_type;

   typedef struct {
      logic [DW-1:0] quotient;
      logic [DW-1:0] remainder;
      logic          divide_by_zero;
   } div_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   // dividend, divisor
   logic [TDATA_W-1:0] req_tdata = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   // quotient, remainder
   logic [TDATA_W-1:0] rsp_tdata;
   // divide_by_zero
   logic               rsp_tuser;

   div_item_type   operand_queue[$];
   div_result_type awaited_divisions[$];
   int unsigned recv_stall_pct = 0;
   int unsigned quiet_cycles = 0;
   int unsigned error_count = 0;

   signed_int_divider #(
      .DATA_WIDTH (DW)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   // Truncating division on magnitudes; quotient sign from both, remainder from dividend.
   function automatic div_result_type truncated_divide(logic [DW-1:0] dividend,
                                                       logic [DW-1:0] divisor);
      div_result_type res;
      logic [DW-1:0]  mag_a;
      logic [DW-1:0]  mag_b;
      logic [DW-1:0]  mag_q;
      logic [DW-1:0]  mag_r;
      if (divisor == '0) begin
         res.quotient       = '0;
         res.remainder      = dividend;
         res.divide_by_zero = 1'b1;
         return res;
      end
      mag_a = dividend[DW-1] ? -dividend : dividend;
      mag_b = divisor[DW-1] ? -divisor : divisor;
      mag_q = mag_a / mag_b;
      mag_r = mag_a % mag_b;
      res.quotient       = (dividend[DW-1] != divisor[DW-1]) ? -mag_q : mag_q;
      res.remainder      = dividend[DW-1] ? -mag_r : mag_r;
      res.divide_by_zero = 1'b0;
      return res;
   endfunction

   task automatic queue_item(logic [DW-1:0] dividend, logic [DW-1:0] divisor,
                             int unsigned send_pct, int unsigned stall_pct, bit drain);
      div_item_type it;
      it.dividend       = dividend;
      it.divisor        = divisor;
      it.send_idle_pct  = send_pct;
      it.recv_stall_pct = stall_pct;
      it.wait_drain     = drain;
      operand_queue.push_back(it);
   endtask

   // Mix of full-range, boundary, small and variable-magnitude operands.
   function automatic logic [DW-1:0] random_operand();
      logic [DW-1:0] val;
      int            small_val;
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(5))
               0: val = MOST_NEG;
               1: val = MOST_POS;
               2: val = '0;
               3: val = 1;
               4: val = MINUS_1;
               default: val = MOST_NEG + 1;
            endcase
         end
         1, 2: begin
            small_val = int'($urandom_range(600)) - 300;
            val = small_val;
         end
         3, 4, 5: begin
            val = $urandom >> $urandom_range(DW-1);
            if ($urandom_range(1))
               val = -val;
         end
         default: val = $urandom;
      endcase
      return val;
   endfunction

   // Driver: offer queued items, record the expected result on each accept.
   always @(posedge clock) begin : drive_items
      div_item_type nxt;
      logic         offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            awaited_divisions.push_back(truncated_divide(req_tdata[DW-1:0],
                                                         req_tdata[2*DW-1:DW]));
         // advance only when nothing is held on the bus
         if (!req_tvalid || req_tready) begin
            offer = 1'b0;
            if (operand_queue.size() != 0) begin
               nxt = operand_queue[0];
               if (nxt.wait_drain && awaited_divisions.size() != 0)
                  offer = 1'b0;
               else if ($urandom_range(99) < nxt.send_idle_pct)
                  offer = 1'b0;
               else
                  offer = 1'b1;
            end
            if (offer) begin
               void'(operand_queue.pop_front());
               req_tdata      <= {nxt.divisor, nxt.dividend};
               recv_stall_pct <= nxt.recv_stall_pct;
            end
            req_tvalid <= offer;
         end
      end
   end

   // Monitor: compare each accepted result with the oldest expectation.
   always @(posedge clock) begin : check_results
      div_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_divisions.size() == 0) begin
               $error("unexpected result: quotient %h remainder %h divide_by_zero %b",
                      rsp_tdata[DW-1:0], rsp_tdata[2*DW-1:DW], rsp_tuser);
               error_count++;
            end else begin
               want = awaited_divisions.pop_front();
               if (rsp_tdata[DW-1:0] !== want.quotient) begin
                  $error("quotient: expected %h, got %h", want.quotient, rsp_tdata[DW-1:0]);
                  error_count++;
               end
               if (rsp_tdata[2*DW-1:DW] !== want.remainder) begin
                  $error("remainder: expected %h, got %h",
                         want.remainder, rsp_tdata[2*DW-1:DW]);
                  error_count++;
               end
               if (rsp_tuser !== want.divide_by_zero) begin
                  $error("divide_by_zero: expected %b, got %b",
                         want.divide_by_zero, rsp_tuser);
                  error_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Count cycles in which no item moves on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : stimulus
      int unsigned send_pct[4];
      int unsigned stall_pct[4];
      int          phase;
      logic [DW-1:0] divisor;

      send_pct  = '{0, 79, 0, 20};
      stall_pct = '{0, 0, 79, 20};

      // directed: signs, boundaries, zero divisor, wrap case
      queue_item(0, 1, 0, 0, 0);
      queue_item(7, 2, 0, 0, 0);
      queue_item(-7, 2, 0, 0, 0);
      queue_item(7, -2, 0, 0, 0);
      queue_item(-7, -2, 0, 0, 0);
      queue_item(MOST_NEG, MINUS_1, 0, 0, 0);
      queue_item(MOST_NEG, 1, 0, 0, 0);
      queue_item(MOST_NEG, MOST_NEG, 0, 0, 0);
      queue_item(MOST_POS, MOST_NEG, 0, 0, 0);
      queue_item(MOST_POS, MOST_POS, 0, 0, 0);
      queue_item(MOST_NEG, MOST_POS, 0, 0, 0);
      queue_item(MOST_POS, MINUS_1, 0, 0, 0);
      queue_item(MOST_NEG, 2, 0, 0, 0);
      queue_item(MOST_NEG, 3, 0, 0, 0);
      queue_item(1, MOST_NEG, 0, 0, 0);
      queue_item(MINUS_1, MINUS_1, 0, 0, 0);
      queue_item(0, -5, 0, 0, 0);
      queue_item(123456789, 1000, 0, 0, 0);
      queue_item(-123456789, 1000, 0, 0, 0);
      queue_item(MOST_POS, 0, 0, 0, 0);
      queue_item(MOST_NEG, 0, 0, 0, 0);
      queue_item(0, 0, 0, 0, 0);
      queue_item(MINUS_1, 0, 0, 0, 0);
      queue_item(5, 0, 0, 0, 0);

      // random, in pacing phases; each later phase opens after a full drain
      for (int i = 0; i < RAND_ITEMS; i++) begin
         phase = (i * 4) / RAND_ITEMS;
         divisor = ($urandom_range(99) < 6) ? '0 : random_operand();
         queue_item(random_operand(), divisor, send_pct[phase], stall_pct[phase],
                    (phase != 0) && ((i * 4) % RAND_ITEMS < 4));
      end

      // hold reset at the start, then release it
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (!(operand_queue.size() == 0 && !req_tvalid && awaited_divisions.size() == 0)
             && quiet_cycles < QUIET_MAX)
         @(posedge clock);

      if (quiet_cycles >= QUIET_MAX) begin
         $display("[signed_int_divider] ERROR");
      end else begin
         repeat (TAIL_WAIT) @(posedge clock);
         if (error_count == 0 && awaited_divisions.size() == 0)
            $display("[signed_int_divider] OK");
         else
            $display("[signed_int_divider] ERROR");
      end
      $finish;
   end

endmodule
